FILE: src/pcc_pkg.sv
package pcc_pkg;

	// default width of the error, integral and quotient arithmetic
	localparam int VALUE_WIDTH_DEF = 16;

	localparam int IO_W     = 16;  // setpoint, measured, drive
	localparam int GAIN_W   = 16;
	localparam int LIMIT_W  = 15;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 16;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

	// gains are scaled by this divisor
	localparam int GAIN_SCALE = 1000;
	// 2^(SCALE_LG2-1) < GAIN_SCALE <= 2^SCALE_LG2
	localparam int SCALE_LG2  = $clog2(GAIN_SCALE);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_P       = 8'd0,
		CFG_GAIN_I       = 8'd1,
		CFG_GAIN_D       = 8'd2,
		CFG_OUTPUT_LIMIT = 8'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic [LIMIT_W-1:0]       output_limit;
	} cfg_t;

endpackage

FILE: src/pid_controller_clamped_top.sv
// channel   | dir | signals                               | content
// ----------+-----+---------------------------------------+------------------------------
// s_axis    | in  | tvalid tready tdata[31:0] tuser[0:0]  | sample or clear word
// m_axis    | out | tvalid tready tdata[15:0]             | clamped drive word
// cfg       | in  | valid ready index[7:0] data[15:0]     | register write, always ready
//
// One word per cycle sustained while m_axis_tready is high. After the s_axis accept edge
// a word passes error stage, product stage, sum stage, reciprocal product stage, quotient
// stage and drive register before m_axis_tvalid rises. Error and integral update at the
// accept edge. Reset clears gains, error and integral; output_limit resets to 32767.
// Every stage has its own valid; a stall on m_axis only fills bubbles, s_axis
// keeps taking words until all six stages hold a word.
module pid_controller_clamped_top #(
	parameter int VALUE_WIDTH = pcc_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// s_axis
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [31:0]                   s_axis_tdata,  // [15:0] setpoint, [31:16] measured
	input  logic [0:0]                    s_axis_tuser,  // [0] func: 1 = clear state
	// m_axis
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [15:0]                   m_axis_tdata,  // [15:0] drive
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pcc_pkg::CFG_DAT_W-1:0] cfg_data
);
	import pcc_pkg::*;

	localparam int SUM_W = GAIN_W + VALUE_WIDTH + 2;  // three products, full width
	localparam int CW    = VALUE_WIDTH + IO_W + 1;    // clamp compare width

	cfg_t cfg;

	logic                          e_valid, e_ready;
	logic signed [VALUE_WIDTH-1:0] e_err, e_esum, e_der;
	logic                          m_valid, m_ready;
	logic signed [SUM_W-1:0]       m_sum;
	logic                          d_valid, d_ready;
	logic signed [VALUE_WIDTH-1:0] d_quo;

	logic signed [CW-1:0]          q_x, lim_x, clamp_x;
	logic                          out_valid_q;
	logic [IO_W-1:0]               drive_q;

	assign cfg_ready = 1'b1;

	pcc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// error, derivative and wrapped integral; owns the controller state
	pcc_err_state #(.VALUE_WIDTH(VALUE_WIDTH)) u_err (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.clear     (s_axis_tuser[0]),
		.setpoint  (s_axis_tdata[15:0]),
		.measured  (s_axis_tdata[31:16]),
		.out_valid (e_valid),
		.out_ready (e_ready),
		.err       (e_err),
		.esum      (e_esum),
		.der       (e_der)
	);

	pcc_mac #(.VALUE_WIDTH(VALUE_WIDTH), .SUM_W(SUM_W)) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (e_valid),
		.in_ready  (e_ready),
		.err       (e_err),
		.esum      (e_esum),
		.der       (e_der),
		.out_valid (m_valid),
		.out_ready (m_ready),
		.sum       (m_sum)
	);

	pcc_div1000 #(.VALUE_WIDTH(VALUE_WIDTH), .SUM_W(SUM_W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (m_valid),
		.in_ready  (m_ready),
		.sum       (m_sum),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.quo       (d_quo)
	);

	// symmetric clamp; the user keeps the limit static while words are in flight, unchecked by the block
	assign q_x   = CW'(d_quo);
	assign lim_x = CW'($signed({1'b0, cfg.output_limit}));

	always_comb begin
		if (q_x > lim_x) begin
			clamp_x = lim_x;
		end else if (q_x < -lim_x) begin
			clamp_x = -lim_x;
		end else begin
			clamp_x = q_x;
		end
	end

	// drive register
	assign d_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (d_ready) begin
			out_valid_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (d_ready && d_valid) begin
			drive_q <= clamp_x[IO_W-1:0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = drive_q;

endmodule

FILE: src/pcc_cfg_regs.sv
module pcc_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic [pcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pcc_pkg::CFG_DAT_W-1:0] cfg_data,
	output pcc_pkg::cfg_t                cfg
);
	import pcc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p       <= '0;
			cfg_q.gain_i       <= '0;
			cfg_q.gain_d       <= '0;
			cfg_q.output_limit <= LIMIT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_GAIN_P:       cfg_q.gain_p <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_I:       cfg_q.gain_i <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_D:       cfg_q.gain_d <= cfg_data[GAIN_W-1:0];
				CFG_OUTPUT_LIMIT: cfg_q.output_limit <= cfg_data[LIMIT_W-1:0];
				default: ;  // unknown index: dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: src/pcc_err_state.sv
module pcc_err_state #(
	parameter int VALUE_WIDTH = pcc_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                clear,
	input  logic signed [pcc_pkg::IO_W-1:0]     setpoint,
	input  logic signed [pcc_pkg::IO_W-1:0]     measured,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [VALUE_WIDTH-1:0]       err,
	output logic signed [VALUE_WIDTH-1:0]       esum,
	output logic signed [VALUE_WIDTH-1:0]       der
);
	import pcc_pkg::*;

	localparam int XW = VALUE_WIDTH + IO_W + 1;

	logic signed [XW-1:0]          diff;
	logic signed [VALUE_WIDTH-1:0] err_d, der_d, esum_d;
	logic signed [VALUE_WIDTH-1:0] last_error_q, error_sum_q;
	logic signed [VALUE_WIDTH-1:0] err_s1, esum_s1, der_s1;
	logic                          v_s1;
	logic                          take;

	assign diff   = XW'(setpoint) - XW'(measured);
	assign err_d  = diff[VALUE_WIDTH-1:0];
	assign der_d  = err_d - last_error_q;
	assign esum_d = error_sum_q + err_d;

	assign in_ready = !v_s1 || out_ready;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_error_q <= '0;
			error_sum_q  <= '0;
			v_s1         <= 1'b0;
		end else begin
			if (take) begin
				if (clear) begin
					last_error_q <= '0;
					error_sum_q  <= '0;
				end else begin
					last_error_q <= err_d;
					error_sum_q  <= esum_d;
				end
			end
			if (in_ready) begin
				v_s1 <= in_valid && !clear;  // clear words leave no result
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && !clear) begin
			err_s1  <= err_d;
			esum_s1 <= esum_d;
			der_s1  <= der_d;
		end
	end

	assign out_valid = v_s1;
	assign err       = err_s1;
	assign esum      = esum_s1;
	assign der       = der_s1;

endmodule

FILE: src/pcc_mac.sv
module pcc_mac #(
	parameter int VALUE_WIDTH = pcc_pkg::VALUE_WIDTH_DEF,
	parameter int SUM_W       = pcc_pkg::GAIN_W + pcc_pkg::VALUE_WIDTH_DEF + 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pcc_pkg::cfg_t                 cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [VALUE_WIDTH-1:0] err,
	input  logic signed [VALUE_WIDTH-1:0] esum,
	input  logic signed [VALUE_WIDTH-1:0] der,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SUM_W-1:0]       sum
);
	import pcc_pkg::*;

	localparam int PW = GAIN_W + VALUE_WIDTH;

	logic signed [PW-1:0]    pp_d, pi_d, pd_d;
	logic signed [PW-1:0]    pp_s2, pi_s2, pd_s2;
	logic signed [SUM_W-1:0] sum_s3;
	logic                    v_s2, v_s3;
	logic                    rdy_s2, rdy_s3;

	assign pp_d = $signed(cfg.gain_p) * err;
	assign pi_d = $signed(cfg.gain_i) * esum;
	assign pd_d = $signed(cfg.gain_d) * der;

	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign in_ready = rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s2) v_s2 <= in_valid;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && in_valid) begin
			pp_s2 <= pp_d;
			pi_s2 <= pi_d;
			pd_s2 <= pd_d;
		end
		if (rdy_s3 && v_s2) begin
			sum_s3 <= SUM_W'(pp_s2) + SUM_W'(pi_s2) + SUM_W'(pd_s2);
		end
	end

	assign out_valid = v_s3;
	assign sum       = sum_s3;

endmodule

FILE: src/pcc_div1000.sv
// Signed divide by GAIN_SCALE, truncating toward zero. The magnitude is
// multiplied by a rounded-up reciprocal, exact for any SUM_W-bit magnitude;
// the product is split into four half-width partial products (stage 4) and
// summed and shifted in stage 5. Only the low VALUE_WIDTH quotient bits are kept.
module pcc_div1000 #(
	parameter int VALUE_WIDTH = pcc_pkg::VALUE_WIDTH_DEF,
	parameter int SUM_W       = pcc_pkg::GAIN_W + pcc_pkg::VALUE_WIDTH_DEF + 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SUM_W-1:0]       sum,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [VALUE_WIDTH-1:0] quo
);
	import pcc_pkg::*;

	localparam int SHIFT = SUM_W + SCALE_LG2;
	localparam int RW    = SUM_W + 1;
	localparam logic [63:0] RECIP64 =
		((64'd1 << SHIFT) + 64'(GAIN_SCALE - 1)) / 64'(GAIN_SCALE);
	localparam logic [RW-1:0] RECIP = RECIP64[RW-1:0];

	// operand halves
	localparam int AL = (SUM_W + 1) / 2;
	localparam int AH = SUM_W - AL;
	localparam int BL = (RW + 1) / 2;
	localparam int BH = RW - BL;
	localparam int PW = SUM_W + RW;

	logic                   in_neg;
	logic [SUM_W-1:0]       mag;
	logic [AL+BL-1:0]       ll_d, ll_s4;
	logic [AL+BH-1:0]       lh_d, lh_s4;
	logic [AH+BL-1:0]       hl_d, hl_s4;
	logic [AH+BH-1:0]       hh_d, hh_s4;
	logic                   neg_s4, neg_s5;
	logic                   v_s4, v_s5;
	logic                   rdy_s4, rdy_s5;
	logic [PW-1:0]          prod;
	logic [VALUE_WIDTH-1:0] qmag, qmag_s5;

	assign in_neg = sum[SUM_W-1];
	assign mag    = in_neg ? SUM_W'(-sum) : SUM_W'(sum);

	assign ll_d = (AL+BL)'(mag[AL-1:0]) * (AL+BL)'(RECIP[BL-1:0]);
	assign lh_d = (AL+BH)'(mag[AL-1:0]) * (AL+BH)'(RECIP[RW-1:BL]);
	assign hl_d = (AH+BL)'(mag[SUM_W-1:AL]) * (AH+BL)'(RECIP[BL-1:0]);
	assign hh_d = (AH+BH)'(mag[SUM_W-1:AL]) * (AH+BH)'(RECIP[RW-1:BL]);

	assign prod = (PW'(hh_s4) << (AL + BL)) + (PW'(hl_s4) << AL)
		+ (PW'(lh_s4) << BL) + PW'(ll_s4);
	assign qmag = prod[SHIFT +: VALUE_WIDTH];

	assign rdy_s5   = !v_s5 || out_ready;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign in_ready = rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s4) v_s4 <= in_valid;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && in_valid) begin
			neg_s4 <= in_neg;
			ll_s4  <= ll_d;
			lh_s4  <= lh_d;
			hl_s4  <= hl_d;
			hh_s4  <= hh_d;
		end
		if (rdy_s5 && v_s4) begin
			neg_s5  <= neg_s4;
			qmag_s5 <= qmag;
		end
	end

	assign out_valid = v_s5;
	assign quo       = neg_s5 ? -qmag_s5 : qmag_s5;

endmodule
